// ----- hw/rtl/lphm_pkg.sv -----
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types, codes and hash helpers for the linear-probe hash map.
// ----------------------------------------------------------------------------
package lphm_pkg;

   localparam int TABLE_SLOTS_DEF = 4096;
   localparam int CNT_W           = 12;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 12'd2047;

   // Register index (byte address bit 2)
   localparam logic REG_MAX_ENTRIES = 1'b0;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_SET = 1'b1;

   typedef enum logic [2:0] {
      STAT_INSERTED     = 3'd0,
      STAT_OVERWRITTEN  = 3'd1,
      STAT_FOUND        = 3'd2,
      STAT_NOT_FOUND    = 3'd3,
      STAT_ZERO_IGNORED = 3'd4,
      STAT_FULL         = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_LOOKUP,
      S_PROBE
   } state_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic signed [15:0] new_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] read_value;
      logic [2:0]         status;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key_x;
      logic [31:0] key_y;
      logic [31:0] key_z;
      logic [15:0] value;
   } entry_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;
      logic hash;
      logic load_home;
      logic advance;
      logic finish;
      logic clear;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic slot_empty;
      logic key_hit;
      logic last_probe;
      logic rsp_busy;
   } sts_type;

   function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
      asr32 = 32'($signed(v) >>> s);
   endfunction

   // First half of the integer mix: invert-add, xor-shift, times five.
   function automatic logic [31:0] mix_head(input logic [31:0] k);
      logic [31:0] a;
      logic [31:0] b;
      a        = ~k + (k << 15);
      b        = a ^ asr32(a, 12);
      mix_head = b + (b << 2);
   endfunction

   // Second half: xor-shift, times 2057 as shift-adds, xor-shift.
   function automatic logic [31:0] mix_tail(input logic [31:0] k);
      logic [31:0] a;
      logic [31:0] b;
      a        = k ^ asr32(k, 4);
      b        = (a << 11) + (a << 3) + a;
      mix_tail = b ^ asr32(b, 16);
   endfunction

endpackage

// ----- hw/rtl/lphm_ram.sv -----
// ----------------------------------------------------------------------------
// lphm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lphm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lphm_ctrl.sv -----
// ----------------------------------------------------------------------------
// lphm_ctrl
// Sequencer: clearing pass, hash, probe loop and result hand-off.
// ----------------------------------------------------------------------------
module lphm_ctrl
   import lphm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      probe_done;

   assign probe_done = sts.slot_empty | sts.key_hit | sts.last_probe;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_HASH;
            end
         end
         S_HASH:   state_in = S_LOOKUP;
         S_LOOKUP: state_in = S_PROBE;
         S_PROBE: begin
            if (probe_done && !sts.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR:  cmd.clear = 1'b1;
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_HASH:   cmd.hash      = 1'b1;
         S_LOOKUP: cmd.load_home = 1'b1;
         S_PROBE: begin
            cmd.advance = !probe_done;
            cmd.finish  = probe_done && !sts.rsp_busy;
         end
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ----- hw/rtl/lphm_dp.sv -----
// ----------------------------------------------------------------------------
// lphm_dp
// Datapath: item and hash registers, probe index, slot RAM, result register.
// ----------------------------------------------------------------------------
module lphm_dp
   import lphm_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  req_type          req_data,
   input  logic [CNT_W-1:0] max_entries,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);

   req_type           item_ff;
   logic [31:0]       mix_x_ff;
   logic [31:0]       mix_y_ff;
   logic [31:0]       mix_z_ff;
   logic [31:0]       home_full;
   logic [SLOT_W-1:0] home;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] idx_in;
   logic [SLOT_W-1:0] probe_ff;
   logic [SLOT_W-1:0] clr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              count_inc;
   entry_type         rd_entry;
   entry_type         wr_entry;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic              key_hit;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   // Hash: head stage registered, tail stage feeds the RAM address.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.hash) begin
         mix_x_ff <= mix_head(item_ff.coord_x);
         mix_y_ff <= mix_head(item_ff.coord_y);
         mix_z_ff <= mix_head(item_ff.coord_z);
      end
   end

   assign home_full = mix_tail(mix_x_ff) ^ mix_tail(mix_y_ff) ^ mix_tail(mix_z_ff);
   assign home      = home_full[SLOT_W-1:0];
   assign idx_in    = cmd.load_home ? home : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load_home || cmd.advance) begin
         idx_ff <= idx_in;
      end
      if (cmd.load_home) begin
         probe_ff <= '0;
      end else if (cmd.advance) begin
         probe_ff <= probe_ff + 1'b1;
      end
   end

   lphm_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.load_home | cmd.advance),
      .rd_addr (idx_in),
      .rd_data (rd_entry)
   );

   assign key_hit = rd_entry.valid &&
                    rd_entry.key_x == item_ff.coord_x &&
                    rd_entry.key_y == item_ff.coord_y &&
                    rd_entry.key_z == item_ff.coord_z;

   always_comb begin
      wr_en             = 1'b0;
      wr_addr           = idx_ff;
      wr_entry          = rd_entry;
      count_inc         = 1'b0;
      rsp_in.read_value = '0;
      rsp_in.status     = STAT_NOT_FOUND;
      if (cmd.clear) begin
         wr_en    = 1'b1;
         wr_addr  = clr_ff;
         wr_entry = '0;
      end else if (cmd.finish) begin
         if (item_ff.kind == KIND_GET) begin
            if (key_hit) begin
               rsp_in.read_value = rd_entry.value;
               rsp_in.status     = STAT_FOUND;
            end
         end else if (key_hit) begin
            wr_en          = 1'b1;
            wr_entry.value = item_ff.new_value;
            rsp_in.status  = STAT_OVERWRITTEN;
         end else if (item_ff.new_value == '0) begin
            rsp_in.status = STAT_ZERO_IGNORED;
         end else if (rd_entry.valid || count_ff >= max_entries) begin
            rsp_in.status = STAT_FULL;
         end else begin
            wr_en          = 1'b1;
            wr_entry.valid = 1'b1;
            wr_entry.key_x = item_ff.coord_x;
            wr_entry.key_y = item_ff.coord_y;
            wr_entry.key_z = item_ff.coord_z;
            wr_entry.value = item_ff.new_value;
            count_inc      = 1'b1;
            rsp_in.status  = STAT_INSERTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (count_inc) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.clear_last = &clr_ff;
   assign sts.slot_empty = !rd_entry.valid;
   assign sts.key_hit    = key_hit;
   assign sts.last_probe = &probe_ff;
   assign sts.rsp_busy   = rsp_valid_ff & rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/linear_probe_hash_map.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open-addressing hash table with linear probing, keyed by three coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one get or set beat (kind, coord_x/y/z, new_value); it is
//   taken when req_valid is high and req_stall is low. Every request yields
//   exactly one rsp_* beat (read_value, status), in request order.
//   A request passes through the hash, lookup and probe states before rsp_valid;
//   while probing, one slot is read per cycle from the single read port of the
//   slot RAM.
//   Only one item is in flight; the next request is taken as soon as the
//   previous one has reached the result register, even while that result
//   still waits under rsp_stall. A finished probe holds until the result
//   register is free.
//   Reset: a clearing pass writes every slot empty, one slot per cycle, and
//   requests stall until it ends. The APB register max_entries (address 0,
//   reset 2047) is writable at any time while idle, including during the
//   clearing pass.
// ----------------------------------------------------------------------------
module linear_probe_hash_map
   import lphm_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cmd_type          cmd;
   sts_type          sts;
   logic [CNT_W-1:0] max_entries_ff;
   logic [CNT_W-1:0] max_entries_in;
   logic             reg_index;
   logic             csr_write;

   // Register file: one register, word index in address bit 2.
   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      max_entries_in = max_entries_ff;
      if (csr_write && reg_index == REG_MAX_ENTRIES) begin
         max_entries_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RST;
      end else begin
         max_entries_ff <= max_entries_in;
      end
   end

   // Reads of unmapped addresses return zero.
   always_comb begin
      prdata = '0;
      if (reg_index == REG_MAX_ENTRIES) begin
         prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, max_entries_ff};
      end
   end

   // Sequencer: clear pass, then hash -> lookup -> probe per beat.
   lphm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: hash, slot RAM, occupancy count, result register.
   lphm_dp #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .max_entries (max_entries_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
